>>> rtl/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit string converter package
// Shared constants, control structs and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    localparam int RADIX_W     = 6;
    localparam int MIN_W       = 6;
    localparam int CHAR_W      = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A     = 8'h41;
    localparam logic [CHAR_W-1:0]  CHAR_NONE   = 8'h00;

    // Per-command control, decided by the front end
    typedef struct packed {
        logic               is_empty;
        logic [RADIX_W-1:0] radix;
    } t_cmd_ctl;

    // One result character
    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              empty_res;
    } t_res;

    // Digit value (0..35) to '0'-'9' / 'A'-'Z'
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (d < 6'd10) begin
            return ASCII_ZERO + d_ext;
        end else begin
            return ASCII_A + d_ext - 8'd10;
        end
    endfunction

endpackage

>>> rtl/rdsc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rdsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/rdsc_fifo.sv
// ----------------------------------------------------------------------------
// Small synchronous FIFO
// Register-based queue; DEPTH must be a power of two, at least 2.
// ----------------------------------------------------------------------------
module rdsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill level update; pointers wrap naturally
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/rdsc_front.sv
// ----------------------------------------------------------------------------
// Converter front end
// Holds the radix register, saturates the minimum and flags empty results.
// ----------------------------------------------------------------------------
module rdsc_front #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rdsc_pkg::RADIX_W-1:0]        i_cfg_data,
    // incoming item
    input  logic [VALUE_WIDTH-1:0]              i_value,
    input  logic [rdsc_pkg::MIN_W-1:0]          i_min_digits,
    // classified command
    output logic [VALUE_WIDTH-1:0]              o_cmd_value,
    output logic [$clog2(MAX_DIGITS+1)-1:0]     o_cmd_min,
    output rdsc_pkg::t_cmd_ctl                  o_cmd_ctl
);

    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic [rdsc_pkg::RADIX_W-1:0] r_radix;
    logic                         radix_ok;
    logic                         zero_run;

    assign o_cfg_ready = 1'b1;

    // Radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rdsc_pkg::RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_data;
        end
    end

    // Classification: bad radix or zero value with zero minimum gives no digits
    assign radix_ok = (r_radix >= rdsc_pkg::RADIX_MIN) && (r_radix <= rdsc_pkg::RADIX_MAX);
    assign zero_run = (i_value == '0) && (i_min_digits == '0);

    always_comb begin
        o_cmd_value        = i_value;
        o_cmd_ctl.is_empty = !radix_ok || zero_run;
        o_cmd_ctl.radix    = r_radix;
        // minimum saturates at the buffer depth
        if ({1'b0, i_min_digits} > 7'(MAX_DIGITS)) begin
            o_cmd_min = CW'(MAX_DIGITS);
        end else begin
            o_cmd_min = CW'(i_min_digits);
        end
    end

endmodule

>>> rtl/rdsc_back.sv
// ----------------------------------------------------------------------------
// Converter back end
// Bit-serial division by the radix, digit storage, reversed character output.
// ----------------------------------------------------------------------------
module rdsc_back #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command queue side
    input  logic                            i_cmd_empty,
    input  logic [VALUE_WIDTH-1:0]          i_cmd_value,
    input  logic [$clog2(MAX_DIGITS+1)-1:0] i_cmd_min,
    input  rdsc_pkg::t_cmd_ctl              i_cmd_ctl,
    output logic                            o_cmd_pop,
    // result queue side
    input  logic                            i_res_full,
    output logic                            o_res_push,
    output rdsc_pkg::t_res                  o_res
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int SW = $clog2(VALUE_WIDTH);
    localparam int RW = rdsc_pkg::RADIX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_PUSH
    } t_state;

    t_state           r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_v, n_v;
    logic [RW-1:0]    r_rem,   n_rem;
    logic [RW-1:0]    r_radix, n_radix;
    logic [CW-1:0]    r_min,   n_min;
    logic [CW-1:0]    r_cnt,   n_cnt;
    logic [SW-1:0]    r_step,  n_step;
    logic [AW-1:0]    r_idx,   n_idx;

    logic [RW:0]      rem_sh;
    logic [RW:0]      rem_sub;
    logic             ge;
    logic [RW-1:0]    rem_new;
    logic [VALUE_WIDTH-1:0] quot;
    logic [CW-1:0]    cnt_inc;
    logic             more;
    logic             step_last;

    logic             ram_wr_en;
    logic             ram_rd_en;
    logic [RW-1:0]    ram_rd_data;

    // One restoring division step per cycle
    assign rem_sh    = {r_rem, r_v[VALUE_WIDTH-1]};
    assign rem_sub   = rem_sh - {1'b0, r_radix};
    assign ge        = (rem_sh >= {1'b0, r_radix});
    assign rem_new   = ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
    assign quot      = {r_v[VALUE_WIDTH-2:0], ge};
    assign step_last = (r_step == SW'(VALUE_WIDTH - 1));
    assign cnt_inc   = r_cnt + 1'b1;
    assign more      = ((quot != '0) || (cnt_inc < r_min)) && (cnt_inc < CW'(MAX_DIGITS));

    assign ram_wr_en = (r_state == ST_DIV) && step_last;
    assign ram_rd_en = (r_state == ST_RD);

    // Digit buffer, least significant digit at address 0
    rdsc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_DIGITS)
    ) u_digit_buf (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (rem_new),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_v        = r_v;
        n_rem      = r_rem;
        n_radix    = r_radix;
        n_min      = r_min;
        n_cnt      = r_cnt;
        n_step     = r_step;
        n_idx      = r_idx;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res.digit_char = rdsc_pkg::digit_to_ascii(ram_rd_data);
        o_res.last       = (r_idx == '0);
        o_res.empty_res  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd_ctl.is_empty) begin
                        // single empty marker
                        o_res.digit_char = rdsc_pkg::CHAR_NONE;
                        o_res.last       = 1'b1;
                        o_res.empty_res  = 1'b1;
                        if (!i_res_full) begin
                            o_res_push = 1'b1;
                            o_cmd_pop  = 1'b1;
                            n_cnt      = '0;
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                        n_v       = i_cmd_value;
                        n_min     = i_cmd_min;
                        n_radix   = i_cmd_ctl.radix;
                        n_rem     = '0;
                        n_step    = '0;
                        n_cnt     = '0;
                        n_state   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_v    = quot;
                n_rem  = rem_new;
                n_step = r_step + 1'b1;
                if (step_last) begin
                    // digit written this cycle at index r_cnt
                    n_cnt  = cnt_inc;
                    n_rem  = '0;
                    n_step = '0;
                    if (!more) begin
                        n_idx   = r_cnt[AW-1:0];
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_v     <= n_v;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_min   <= n_min;
        r_step  <= n_step;
        r_idx   <= n_idx;
    end

endmodule

>>> rtl/radix_digit_string_converter.sv
// ----------------------------------------------------------------------------
// Radix digit string converter
// Converts an unsigned value to an ASCII digit string in a programmable radix.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_value and i_min_digits with i_push; a transfer takes
//   place when i_push is high and o_full is low. Two commands can wait.
//   Result queue: while o_empty is low the oldest character sits on
//   o_digit_char / o_last / o_empty_res; i_pop takes it.
//   Configuration: i_cfg_data is written to the radix register on a transfer
//   of i_cfg_valid / o_cfg_ready (always ready); write only when idle.
//   Characters leave most significant first, padded with '0' to the minimum,
//   o_last on the final one. A bad radix or a zero value with zero minimum
//   gives one result with o_empty_res set and o_digit_char zero.
// Operation:
//   Each digit comes from the one-bit-per-cycle divider, and each character
//   is read back through the digit RAM read port before it is pushed.
//   Items are handled one at a time.
// Reset: synchronous, active low; radix returns to 10, both queues empty.
// A stalled result queue holds the back end; the input queue keeps filling.
// ----------------------------------------------------------------------------
module radix_digit_string_converter #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rdsc_pkg::RADIX_W-1:0]  i_cfg_data,
    // input queue
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [VALUE_WIDTH-1:0]        i_value,
    input  logic [rdsc_pkg::MIN_W-1:0]    i_min_digits,
    // result queue
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [rdsc_pkg::CHAR_W-1:0]   o_digit_char,
    output logic                          o_last,
    output logic                          o_empty_res
);

    localparam int CW     = $clog2(MAX_DIGITS + 1);
    localparam int CTL_W  = $bits(rdsc_pkg::t_cmd_ctl);
    localparam int CMD_W  = VALUE_WIDTH + CW + CTL_W;
    localparam int RES_W  = $bits(rdsc_pkg::t_res);

    logic [VALUE_WIDTH-1:0]  fe_value;
    logic [CW-1:0]           fe_min;
    rdsc_pkg::t_cmd_ctl      fe_ctl;

    logic [CMD_W-1:0]        cmd_wdata, cmd_rdata;
    logic                    cmd_empty, cmd_pop;
    logic [VALUE_WIDTH-1:0]  be_value;
    logic [CW-1:0]           be_min;
    rdsc_pkg::t_cmd_ctl      be_ctl;

    rdsc_pkg::t_res          be_res, out_res;
    logic                    res_push, res_full;
    logic [RES_W-1:0]        res_rdata;

    // Front end
    rdsc_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_value      (i_value),
        .i_min_digits (i_min_digits),
        .o_cmd_value  (fe_value),
        .o_cmd_min    (fe_min),
        .o_cmd_ctl    (fe_ctl)
    );

    // Command queue between front and back
    assign cmd_wdata = {fe_value, fe_min, fe_ctl};

    rdsc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_wdata),
        .o_full  (o_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_rdata),
        .o_empty (cmd_empty)
    );

    assign {be_value, be_min, be_ctl} = cmd_rdata;

    // Back end
    rdsc_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd_value (be_value),
        .i_cmd_min   (be_min),
        .i_cmd_ctl   (be_ctl),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (be_res)
    );

    // Result queue
    rdsc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (be_res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_rdata),
        .o_empty (o_empty)
    );

    assign out_res      = res_rdata;
    assign o_digit_char = out_res.digit_char;
    assign o_last       = out_res.last;
    assign o_empty_res  = out_res.empty_res;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for radix_digit_string_converter
// Pushes values and minimum digit counts through the input queue. The
// expected ASCII digit strings are worked out in the bench and compared
// character by character as results are popped. Covers radix 2, 3, 7, 8,
// 10, 16, 36, one random base, bad radixes, padding and its saturation,
// a long result stall, random sender bursts and random receiver stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int RADIX_W = rdsc_pkg::RADIX_W;
    localparam int MIN_W   = rdsc_pkg::MIN_W;
    localparam int CHAR_W  = rdsc_pkg::CHAR_W;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned HOLD_CYCLES = 3000;
    localparam int unsigned TAIL_CYCLES = 1100;
    localparam int unsigned SWEEP_ITEMS = 46;
    localparam int unsigned MAX_CHARS   = 32;

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [RADIX_W-1:0]   i_cfg_data   = '0;
    logic                 i_push       = 1'b0;
    logic                 o_full;
    logic [31:0]          i_value      = '0;
    logic [MIN_W-1:0]     i_min_digits = '0;
    logic                 o_empty;
    logic                 i_pop        = 1'b0;
    logic [CHAR_W-1:0]    o_digit_char;
    logic                 o_last;
    logic                 o_empty_res;

    // Bench state
    logic [RADIX_W-1:0]   radix_cfg;
    rdsc_pkg::t_res       exp_chars[$];
    int unsigned          err_count;
    int unsigned          cycle_count;
    int unsigned          burst_left;
    logic                 hold_req;

    radix_digit_string_converter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_value      (i_value),
        .i_min_digits (i_min_digits),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_empty_res  (o_empty_res)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Append one character to the expected stream
    function automatic void queue_expected(input rdsc_pkg::t_res r);
        exp_chars = {exp_chars, r};
    endfunction

    // Expected character string for one value at the current radix
    function automatic void predict_string(input logic [31:0] val, input logic [MIN_W-1:0] min_in);
        logic [RADIX_W-1:0] digs [MAX_CHARS];
        logic [31:0]        rest;
        int unsigned        want;
        int unsigned        n;
        int                 k;
        rdsc_pkg::t_res     r;
        want = (min_in > MAX_CHARS) ? MAX_CHARS : min_in;
        if (radix_cfg < rdsc_pkg::RADIX_MIN || radix_cfg > rdsc_pkg::RADIX_MAX ||
            (val == 0 && want == 0)) begin
            r.digit_char = rdsc_pkg::CHAR_NONE;
            r.last       = 1'b1;
            r.empty_res  = 1'b1;
            queue_expected(r);
            return;
        end
        n    = 0;
        rest = val;
        while ((rest != 0 || n < want) && n < MAX_CHARS) begin
            digs[n] = RADIX_W'(rest % radix_cfg);
            rest    = rest / radix_cfg;
            n++;
        end
        // most significant digit leaves first
        for (k = int'(n) - 1; k >= 0; k--) begin
            if (digs[k] < 10) begin
                r.digit_char = rdsc_pkg::ASCII_ZERO + CHAR_W'(digs[k]);
            end else begin
                r.digit_char = rdsc_pkg::ASCII_A + CHAR_W'(digs[k]) - 8'd10;
            end
            r.last      = (k == 0);
            r.empty_res = 1'b0;
            queue_expected(r);
        end
    endfunction

    // Compare one popped character with the oldest expectation
    task automatic check_char();
        rdsc_pkg::t_res want;
        if (exp_chars.size() == 0) begin
            $display("%0t: unexpected result: char %h last %b empty %b",
                     $time, o_digit_char, o_last, o_empty_res);
            err_count++;
            return;
        end
        want = exp_chars.pop_front();
        if (o_digit_char !== want.digit_char) begin
            $display("%0t: digit_char expected %h actual %h",
                     $time, want.digit_char, o_digit_char);
            err_count++;
        end
        if (o_last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, o_last);
            err_count++;
        end
        if (o_empty_res !== want.empty_res) begin
            $display("%0t: empty_res expected %b actual %b",
                     $time, want.empty_res, o_empty_res);
            err_count++;
        end
    endtask

    // Result side: check each transfer, then choose the next pop
    initial begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) begin
                check_char();
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 256);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                unique case (mode)
                    0, 1: i_pop <= 1'b1;
                    2:    i_pop <= 1'($urandom_range(0, 1));
                    default: i_pop <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // One input transfer; push stays high for the caller to reuse
    task automatic push_item(input logic [31:0] v, input logic [MIN_W-1:0] m);
        i_push       <= 1'b1;
        i_value      <= v;
        i_min_digits <= m;
        do @(posedge i_clk); while (o_full);
        predict_string(v, m);
    endtask

    // Transfer in bursts with random gaps between them
    task automatic send_item(input logic [31:0] v, input logic [MIN_W-1:0] m);
        int unsigned gap;
        push_item(v, m);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap != 0) begin
                i_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // Sender pauses until every expected character has been popped
    task automatic wait_idle();
        i_push <= 1'b0;
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        radix_cfg = r;
    endtask

    function automatic logic [31:0] pick_value();
        unique case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 40);
            1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            2:       return $urandom >> $urandom_range(1, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MIN_W-1:0] pick_min();
        if ($urandom_range(0, 7) == 0) return MIN_W'($urandom_range(0, 63));
        return MIN_W'($urandom_range(0, 12));
    endfunction

    // Reset radix of ten: zero cases, full range, padding and its saturation
    task automatic test_default_radix();
        push_item(32'd0, 6'd0);
        push_item(32'd0, 6'd1);
        push_item(32'hFFFF_FFFF, 6'd0);
        push_item(32'd1, 6'd32);
        push_item(32'd12345, 6'd63);
        push_item(32'd7, 6'd33);
        push_item(32'd0, 6'd32);
        wait_idle();
    endtask

    // Largest and smallest bases, plus hex
    task automatic test_radix_extremes();
        write_radix(rdsc_pkg::RADIX_MAX);
        push_item(32'hFFFF_FFFF, 6'd0);
        push_item(32'd35, 6'd0);
        push_item(32'd36, 6'd3);
        wait_idle();
        write_radix(rdsc_pkg::RADIX_MIN);
        push_item(32'hFFFF_FFFF, 6'd0);
        push_item(32'h8000_0000, 6'd0);
        push_item(32'd5, 6'd40);
        wait_idle();
        write_radix(6'd16);
        push_item(32'hDEAD_BEEF, 6'd0);
        push_item(32'h0000_00A5, 6'd4);
        wait_idle();
    endtask

    // Bases outside 2..36 give one empty result
    task automatic test_bad_radix();
        logic [RADIX_W-1:0] bad [4];
        int                 i;
        bad = '{6'd0, 6'd1, 6'd37, 6'd63};
        for (i = 0; i < 4; i++) begin
            write_radix(bad[i]);
            push_item($urandom | 32'h1, pick_min());
            wait_idle();
        end
        write_radix(6'd63);
        push_item(32'd0, 6'd0);
        wait_idle();
    endtask

    // Long result stall while items keep coming, so both queues fill up
    task automatic test_backpressure();
        write_radix(rdsc_pkg::RADIX_RESET);
        hold_req = 1'b1;
        repeat (30) push_item($urandom_range(0, 9), MIN_W'($urandom_range(0, 1)));
        wait_idle();
    endtask

    // Random phases, one base each, the extremes among them
    task automatic test_random_sweep();
        logic [RADIX_W-1:0] bases [9];
        int                 p;
        bases[0] = rdsc_pkg::RADIX_RESET;
        bases[1] = rdsc_pkg::RADIX_MIN;
        bases[2] = rdsc_pkg::RADIX_MAX;
        bases[3] = 6'd16;
        bases[4] = 6'd8;
        bases[5] = 6'd3;
        bases[6] = RADIX_W'($urandom_range(2, 36));
        bases[7] = RADIX_W'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                 : $urandom_range(37, 63));
        bases[8] = 6'd7;
        for (p = 0; p < 9; p++) begin
            wait_idle();
            write_radix(bases[p]);
            burst_left = $urandom_range(1, 16);
            repeat (SWEEP_ITEMS) send_item(pick_value(), pick_min());
        end
        wait_idle();
    endtask

    // Test sequence
    initial begin
        err_count  = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        radix_cfg  = rdsc_pkg::RADIX_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_radix();
        test_radix_extremes();
        test_bad_radix();
        test_backpressure();
        test_random_sweep();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && exp_chars.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
